FILE: hw/rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg: shared types, constants and microcode for reversal_sort_positions
// Item payloads, the stored element format and the control store.
// ----------------------------------------------------------------------------
package rsp_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int VAL_W     = 32;
    localparam int ORD_W     = 6;
    localparam int POS_W     = 7;
    localparam int ENTRY_W   = VAL_W + ORD_W;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last_item;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             last_result;
    } result_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [ORD_W-1:0]        order;
    } entry_t;

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_LOAD       = 4'd0;
    localparam logic [OP_W-1:0] OP_INIT       = 4'd1;
    localparam logic [OP_W-1:0] OP_SCAN_START = 4'd2;
    localparam logic [OP_W-1:0] OP_SCAN_FIRST = 4'd3;
    localparam logic [OP_W-1:0] OP_SCAN_CMP   = 4'd4;
    localparam logic [OP_W-1:0] OP_EMIT       = 4'd5;
    localparam logic [OP_W-1:0] OP_SWAP_TEST  = 4'd6;
    localparam logic [OP_W-1:0] OP_SWAP_RD_HI = 4'd7;
    localparam logic [OP_W-1:0] OP_SWAP_WR_LO = 4'd8;
    localparam logic [OP_W-1:0] OP_SWAP_WR_HI = 4'd9;
    localparam logic [OP_W-1:0] OP_NEXT       = 4'd10;
    localparam logic [OP_W-1:0] OP_DONE       = 4'd11;

    // branch kinds
    localparam int BR_W = 2;
    localparam logic [BR_W-1:0] BR_SEQ  = 2'd0;  // pc + 1
    localparam logic [BR_W-1:0] BR_GOTO = 2'd1;  // target
    localparam logic [BR_W-1:0] BR_TRUE = 2'd2;  // target if flag, else pc + 1
    localparam logic [BR_W-1:0] BR_HOLD = 2'd3;  // pc + 1 if flag, else stay

    // branch flags
    localparam int FL_W = 3;
    localparam logic [FL_W-1:0] FL_NONE      = 3'd0;
    localparam logic [FL_W-1:0] FL_LOAD_DONE = 3'd1;
    localparam logic [FL_W-1:0] FL_SCAN_END  = 3'd2;
    localparam logic [FL_W-1:0] FL_SCAN_MORE = 3'd3;
    localparam logic [FL_W-1:0] FL_OUT_FREE  = 3'd4;
    localparam logic [FL_W-1:0] FL_SWAP_DONE = 3'd5;
    localparam logic [FL_W-1:0] FL_MORE_STEP = 3'd6;

    // program steps
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_LOAD       = 4'd0;
    localparam logic [PC_W-1:0] PC_INIT       = 4'd1;
    localparam logic [PC_W-1:0] PC_SCAN_START = 4'd2;
    localparam logic [PC_W-1:0] PC_SCAN_FIRST = 4'd3;
    localparam logic [PC_W-1:0] PC_SCAN_CMP   = 4'd4;
    localparam logic [PC_W-1:0] PC_EMIT       = 4'd5;
    localparam logic [PC_W-1:0] PC_SWAP_TEST  = 4'd6;
    localparam logic [PC_W-1:0] PC_SWAP_RD_HI = 4'd7;
    localparam logic [PC_W-1:0] PC_SWAP_WR_LO = 4'd8;
    localparam logic [PC_W-1:0] PC_SWAP_WR_HI = 4'd9;
    localparam logic [PC_W-1:0] PC_NEXT       = 4'd10;
    localparam logic [PC_W-1:0] PC_DONE       = 4'd11;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [BR_W-1:0] br;
        logic [FL_W-1:0] flag;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // control store
    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            PC_LOAD:       w = '{OP_LOAD,       BR_HOLD, FL_LOAD_DONE, PC_LOAD};
            PC_INIT:       w = '{OP_INIT,       BR_SEQ,  FL_NONE,      PC_LOAD};
            PC_SCAN_START: w = '{OP_SCAN_START, BR_SEQ,  FL_NONE,      PC_LOAD};
            PC_SCAN_FIRST: w = '{OP_SCAN_FIRST, BR_TRUE, FL_SCAN_END,  PC_EMIT};
            PC_SCAN_CMP:   w = '{OP_SCAN_CMP,   BR_TRUE, FL_SCAN_MORE, PC_SCAN_CMP};
            PC_EMIT:       w = '{OP_EMIT,       BR_HOLD, FL_OUT_FREE,  PC_LOAD};
            PC_SWAP_TEST:  w = '{OP_SWAP_TEST,  BR_TRUE, FL_SWAP_DONE, PC_NEXT};
            PC_SWAP_RD_HI: w = '{OP_SWAP_RD_HI, BR_SEQ,  FL_NONE,      PC_LOAD};
            PC_SWAP_WR_LO: w = '{OP_SWAP_WR_LO, BR_SEQ,  FL_NONE,      PC_LOAD};
            PC_SWAP_WR_HI: w = '{OP_SWAP_WR_HI, BR_GOTO, FL_NONE,      PC_SWAP_TEST};
            PC_NEXT:       w = '{OP_NEXT,       BR_TRUE, FL_MORE_STEP, PC_SCAN_START};
            PC_DONE:       w = '{OP_DONE,       BR_GOTO, FL_NONE,      PC_LOAD};
            default:       w = '{OP_DONE,       BR_GOTO, FL_NONE,      PC_LOAD};
        endcase
        return w;
    endfunction

    // strict order by signed value, then by load order
    function automatic logic key_less(input entry_t a, input entry_t b);
        if (a.value != b.value)
            return a.value < b.value;
        return a.order < b.order;
    endfunction

endpackage

FILE: hw/rtl/rsp_ram.sv
// ----------------------------------------------------------------------------
// rsp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/reversal_sort_positions.sv
// ----------------------------------------------------------------------------
// reversal_sort_positions: prefix-reversal sort reporting chosen positions
// Loads signed values, then for each step picks the minimum of the unsorted
// tail, reports its position and reverses the span that brings it forward.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_ready     rsp_pkg::item_t   (value, last_item)
//  result    out        result_valid / result_ready rsp_pkg::result_t (position, last_result)
//
//  item_ready is high only in the load step. Reset (rst_n, async, active low)
//  clears the program counter, count and output valid; the RAM is not
//  cleared, only loaded entries are read. A stalled result holds the emit
//  step until the output register frees up.
//
module reversal_sort_positions (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  rsp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output rsp_pkg::result_t result
);

    // sequencer
    logic [rsp_pkg::PC_W-1:0] pc_reg, pc_next;
    rsp_pkg::ctrl_t           ctrl;
    logic                     flag;

    // datapath registers
    logic [rsp_pkg::CNT_W-1:0] count_reg, count_next;   // n
    logic [rsp_pkg::IDX_W-1:0] i_reg, i_next;           // sort step
    logic [rsp_pkg::CNT_W-1:0] j_reg, j_next;           // scan index, can reach n
    logic [rsp_pkg::IDX_W-1:0] best_reg, best_next;
    rsp_pkg::entry_t           best_key_reg, best_key_next;
    logic [rsp_pkg::IDX_W-1:0] lo_reg, lo_next;
    logic [rsp_pkg::IDX_W-1:0] hi_reg, hi_next;
    rsp_pkg::entry_t           tmp_reg, tmp_next;        // saved mem[lo] during swap

    // output register
    logic             result_valid_reg, result_valid_next;
    rsp_pkg::result_t result_reg, result_next;

    // RAM port signals
    logic                      ram_we;
    logic [rsp_pkg::IDX_W-1:0] ram_waddr;
    rsp_pkg::entry_t           ram_wdata;
    logic [rsp_pkg::IDX_W-1:0] ram_raddr;
    rsp_pkg::entry_t           ram_rdata;
    logic [rsp_pkg::ENTRY_W-1:0] ram_rdata_raw;

    logic                      item_acc;
    logic                      out_free;
    logic                      store_full;
    logic [rsp_pkg::CNT_W-1:0] i_plus1;
    logic [rsp_pkg::CNT_W-1:0] j_plus1;

    rsp_ram #(
        .WIDTH (rsp_pkg::ENTRY_W),
        .DEPTH (rsp_pkg::MAX_ITEMS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = rsp_pkg::entry_t'(ram_rdata_raw);

    assign ctrl       = rsp_pkg::ucode_rom(pc_reg);
    assign item_ready = (ctrl.op == rsp_pkg::OP_LOAD);
    assign item_acc   = item_valid && item_ready;
    assign out_free   = !result_valid_reg || result_ready;
    assign store_full = (count_reg >= rsp_pkg::CNT_W'(rsp_pkg::MAX_ITEMS));
    assign i_plus1    = rsp_pkg::CNT_W'(i_reg) + rsp_pkg::CNT_W'(1);
    assign j_plus1    = j_reg + rsp_pkg::CNT_W'(1);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // branch flag select
    always_comb
    begin
        unique case (ctrl.flag)
            rsp_pkg::FL_LOAD_DONE: flag = item_acc && item.last_item;
            rsp_pkg::FL_SCAN_END:  flag = (j_reg >= count_reg);
            rsp_pkg::FL_SCAN_MORE: flag = (j_plus1 < count_reg);
            rsp_pkg::FL_OUT_FREE:  flag = out_free;
            rsp_pkg::FL_SWAP_DONE: flag = (lo_reg >= hi_reg);
            rsp_pkg::FL_MORE_STEP: flag = (i_plus1 < count_reg);
            default:               flag = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        unique case (ctrl.br)
            rsp_pkg::BR_SEQ:  pc_next = pc_reg + rsp_pkg::PC_W'(1);
            rsp_pkg::BR_GOTO: pc_next = ctrl.target;
            rsp_pkg::BR_TRUE: pc_next = flag ? ctrl.target : pc_reg + rsp_pkg::PC_W'(1);
            rsp_pkg::BR_HOLD: pc_next = flag ? pc_reg + rsp_pkg::PC_W'(1) : pc_reg;
            default:          pc_next = rsp_pkg::PC_LOAD;
        endcase
    end

    // datapath
    always_comb
    begin
        count_next        = count_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        best_next         = best_reg;
        best_key_next     = best_key_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        tmp_next          = tmp_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        ram_we            = 1'b0;
        ram_waddr         = lo_reg;
        ram_wdata         = ram_rdata;
        ram_raddr         = lo_reg;

        unique case (ctrl.op)
            rsp_pkg::OP_LOAD:
            begin
                // a full store drops the item, but its last flag still counts
                if (item_acc && !store_full)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = count_reg[rsp_pkg::IDX_W-1:0];
                    ram_wdata.value = item.value;
                    ram_wdata.order = rsp_pkg::ORD_W'(count_reg);
                    count_next      = count_reg + rsp_pkg::CNT_W'(1);
                end
            end
            rsp_pkg::OP_INIT:
            begin
                i_next = '0;
            end
            rsp_pkg::OP_SCAN_START:
            begin
                ram_raddr = i_reg;
                best_next = i_reg;
                j_next    = i_plus1;
            end
            rsp_pkg::OP_SCAN_FIRST:
            begin
                best_key_next = ram_rdata;
                ram_raddr     = j_reg[rsp_pkg::IDX_W-1:0];
            end
            rsp_pkg::OP_SCAN_CMP:
            begin
                // rdata is mem[j]; fetch j + 1 for the next pass
                if (rsp_pkg::key_less(ram_rdata, best_key_reg))
                begin
                    best_next     = j_reg[rsp_pkg::IDX_W-1:0];
                    best_key_next = ram_rdata;
                end
                j_next    = j_plus1;
                ram_raddr = j_plus1[rsp_pkg::IDX_W-1:0];
            end
            rsp_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next       = 1'b1;
                    result_next.position    = rsp_pkg::POS_W'(best_reg) + rsp_pkg::POS_W'(1);
                    result_next.last_result = (i_plus1 == count_reg);
                    lo_next                 = i_reg;
                    hi_next                 = best_reg;
                end
            end
            rsp_pkg::OP_SWAP_TEST:
            begin
                ram_raddr = lo_reg;
            end
            rsp_pkg::OP_SWAP_RD_HI:
            begin
                tmp_next  = ram_rdata;
                ram_raddr = hi_reg;
            end
            rsp_pkg::OP_SWAP_WR_LO:
            begin
                ram_we    = 1'b1;
                ram_waddr = lo_reg;
                ram_wdata = ram_rdata;
            end
            rsp_pkg::OP_SWAP_WR_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = tmp_reg;
                lo_next   = lo_reg + rsp_pkg::IDX_W'(1);
                hi_next   = hi_reg - rsp_pkg::IDX_W'(1);
            end
            rsp_pkg::OP_NEXT:
            begin
                i_next = i_reg + rsp_pkg::IDX_W'(1);
            end
            rsp_pkg::OP_DONE:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= rsp_pkg::PC_LOAD;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg           <= pc_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        best_reg     <= best_next;
        best_key_reg <= best_key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        tmp_reg      <= tmp_next;
        result_reg   <= result_next;
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rsp_pkg::CNT_W'(rsp_pkg::MAX_ITEMS))
        else $error("element count above store depth");

    a_load_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ctrl.op == rsp_pkg::OP_LOAD) |-> !store_full)
        else $error("write into a full store");

    a_swap_span: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == rsp_pkg::OP_SWAP_RD_HI) |-> (lo_reg < hi_reg))
        else $error("swap issued on an empty span");

    a_best_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == rsp_pkg::OP_EMIT) |->
            (best_reg >= i_reg) && (rsp_pkg::CNT_W'(best_reg) < count_reg))
        else $error("minimum outside the unsorted tail");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == rsp_pkg::OP_EMIT && out_free) |=> result_valid_reg)
        else $error("emit step did not fill the output register");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for reversal_sort_positions
// Feeds value sequences through the item channel with random gaps, keeps its
// own copy of the prefix-reversal sort, and checks every reported position.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic signed [rsp_pkg::VAL_W-1:0] VAL_MIN = {1'b1, {(rsp_pkg::VAL_W-1){1'b0}}};
    localparam logic signed [rsp_pkg::VAL_W-1:0] VAL_MAX = {1'b0, {(rsp_pkg::VAL_W-1){1'b1}}};

    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 600;    // receiver stall, cycles
    localparam int DRAIN_CYCLES = 300;    // quiet time after the last result
    localparam int TIMEOUT_NS   = 800000; // far above the slowest legal run

    // how the values of one sequence are drawn
    typedef enum int {
        STYLE_WIDE,    // any 32-bit pattern
        STYLE_NARROW,  // -3..3, lots of ties
        STYLE_EDGE,    // extremes and values around zero
        STYLE_MIXED    // one of the above per item
    } value_style_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the element store and the sort, queues the positions
    // a pass must report, and checks results in order.
    // ------------------------------------------------------------------------
    class sort_scoreboard;
        rsp_pkg::entry_t           held[rsp_pkg::MAX_ITEMS];
        logic [rsp_pkg::CNT_W-1:0] held_count;
        rsp_pkg::result_t          expected_q[$];
        int                        errors;
        int                        checked;
        int                        passes;
        int                        dropped;

        function new();
            held_count = '0;
            errors     = 0;
            checked    = 0;
            passes     = 0;
            dropped    = 0;
        endfunction

        // (value, load order) strict ordering; ties go to the earlier load
        function bit entry_before(rsp_pkg::entry_t a, rsp_pkg::entry_t b);
            if ($signed(a.value) != $signed(b.value))
                return $signed(a.value) < $signed(b.value);
            return a.order < b.order;
        endfunction

        function void note_item(rsp_pkg::item_t it);
            int               n;
            int               best;
            int               lo;
            int               hi;
            rsp_pkg::entry_t  tmp;
            rsp_pkg::result_t r;
            if (held_count < rsp_pkg::MAX_ITEMS)
            begin
                held[held_count].value = it.value;
                held[held_count].order = held_count[rsp_pkg::ORD_W-1:0];
                held_count++;
            end
            else
            begin
                dropped++;
            end
            if (!it.last_item)
                return;
            n = held_count;
            for (int i = 0; i < n; i++)
            begin
                best = i;
                for (int j = i + 1; j < n; j++)
                    if (entry_before(held[j], held[best]))
                        best = j;
                r.position    = rsp_pkg::POS_W'(best + 1);
                r.last_result = (i + 1 == n);
                expected_q    = {expected_q, r};
                // bring the minimum forward by reversing i..best
                lo = i;
                hi = best;
                while (lo < hi)
                begin
                    tmp      = held[lo];
                    held[lo] = held[hi];
                    held[hi] = tmp;
                    lo++;
                    hi--;
                end
            end
            held_count = '0;
            passes++;
        endfunction

        function void check_result(rsp_pkg::result_t got);
            rsp_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got position %0d last %0b",
                         $time, got.position, got.last_result);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.position !== want.position)
            begin
                $display("%0t: position mismatch: expected %0d, got %0d",
                         $time, want.position, got.position);
                errors++;
            end
            if (got.last_result !== want.last_result)
            begin
                $display("%0t: last_result mismatch: expected %0b, got %0b",
                         $time, want.last_result, got.last_result);
                errors++;
            end
        endfunction

        function int remaining();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT hookup
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    rsp_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    rsp_pkg::result_t result;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    reversal_sort_positions uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    sort_scoreboard sb = new();

    int items_sent    = 0;
    bit sender_burst  = 1'b0;  // sender skips its gaps while set
    bit hold_off_req  = 1'b0;  // asks the receiver for one long stall

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one item after a random gap and wait for the handshake. Valid is
    // only dropped when a gap follows, so back-to-back items keep it high.
    task automatic offer_item(input rsp_pkg::item_t it);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    function automatic logic signed [rsp_pkg::VAL_W-1:0] pick_value(
        input value_style_t style
    );
        value_style_t s;
        s = style;
        if (s == STYLE_MIXED)
            s = value_style_t'($urandom_range(0, 2));
        case (s)
            STYLE_WIDE:   return $urandom;
            STYLE_NARROW: return $signed($urandom_range(0, 6)) - 3;
            default:
            begin
                case ($urandom_range(0, 6))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return VAL_MIN + 1;
                    3:       return VAL_MAX - 1;
                    4:       return -1;
                    5:       return 0;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    // len values, the last one flagged; past MAX_ITEMS the block drops items
    task automatic send_sequence(input int len, input value_style_t style);
        rsp_pkg::item_t it;
        for (int k = 1; k <= len; k++)
        begin
            it.value     = pick_value(style);
            it.last_item = (k == len);
            offer_item(it);
        end
    endtask

    task automatic send_value(input logic signed [rsp_pkg::VAL_W-1:0] v, input logic last);
        rsp_pkg::item_t it;
        it.value     = v;
        it.last_item = last;
        offer_item(it);
    endtask

    // sender pause: valid drops so the accepted item is not offered again,
    // then nothing new until every queued position has come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.remaining() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random ready gaps, zero-gap bursts, one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        int burst_left;
        burst_left = 0;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                // long stall: the output register fills, the sort parks in
                // its emit step and the item channel backs up behind it
                hold_off_req = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (burst_left == 0 && $urandom_range(0, 9) == 0)
                burst_left = 30;
            if (burst_left > 0)
            begin
                burst_left--;
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 9);
            end
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            sb.check_result(result);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int           seq_idx;
        int           len;
        int           target;
        value_style_t style;

        rst_n      = 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // single element: one result, position 1, flagged last
        send_value(VAL_MIN, 1'b1);
        // equal pair: the tie goes to the earlier load
        send_value(5, 1'b0);
        send_value(5, 1'b1);
        // extremes with repeated minimum and maximum
        send_value(VAL_MAX, 1'b0);
        send_value(VAL_MIN, 1'b0);
        send_value(0, 1'b0);
        send_value(-1, 1'b0);
        send_value(1, 1'b0);
        send_value(VAL_MAX, 1'b0);
        send_value(VAL_MIN, 1'b0);
        send_value(-1, 1'b1);
        // descending run: the first step reverses the whole span
        for (int k = 4; k >= 0; k--)
            send_value(k, k == 0);
        // already sorted: every step picks its own position
        send_value(-3, 1'b0);
        send_value(-2, 1'b0);
        send_value(-1, 1'b1);
        wait_drained();

        // ---- random part ----
        // the long receiver stall lands on the first random passes, while
        // the sender keeps offering the next sequences
        hold_off_req = 1'b1;
        target  = items_sent + RANDOM_ITEMS;
        seq_idx = 0;
        while (items_sent < target)
        begin
            style        = value_style_t'($urandom_range(0, 3));
            sender_burst = ($urandom_range(0, 3) == 0);
            if (seq_idx == 4)
                len = rsp_pkg::MAX_ITEMS;       // store exactly full
            else if (seq_idx == 9)
                len = rsp_pkg::MAX_ITEMS + 3;   // overflow, flagged item dropped too
            else if ($urandom_range(0, 4) == 0)
                len = $urandom_range(11, 20);
            else
                len = $urandom_range(1, 10);
            send_sequence(len, style);
            if (seq_idx > 3 && $urandom_range(0, 7) == 0)
                wait_drained();
            seq_idx++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items in %0d sort passes, %0d positions checked,",
                 items_sent, sb.passes, sb.checked);
        $display("including ties, extremes, a full store and %0d dropped items.", sb.dropped);
        if (sb.errors == 0 && sb.remaining() == 0)
            $display("** reversal_sort_positions: PASSED **");
        else
            $display("** reversal_sort_positions: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d positions still outstanding", sb.remaining());
        $display("** reversal_sort_positions: FAILED **");
        $finish;
    end

endmodule
